// ----- hdl/signed_int_to_decimal_ascii_unit_macros.svh -----
// assertion macros for the signed integer to decimal text unit
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`ifndef SYNTH
`define SIDAU_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sidau implication check failed");
`define SIDAU_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sidau next-cycle check failed");
`else
`define SIDAU_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define SIDAU_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ----- hdl/sidau_pkg.sv -----
// shared constants and controller/datapath signal groups
package sidau_pkg;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic shift_digit;
    logic load_sign;
    logic load_digit;
  } sidau_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic top_zero;
    logic rem_one;
    logic negative;
  } sidau_sts_t;

endpackage

// ----- hdl/sidau_if.sv -----
// handshake channels for the input integer and the output characters
interface sidau_in_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sidau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- hdl/sidau_datapath.sv -----
// magnitude, shift-add-3 bcd conversion and character output registers
module sidau_datapath import sidau_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  sidau_cmd_t                    cmd,
  output sidau_sts_t                    sts,
  output logic [7:0]                    char_code,
  output logic                          last
);

  localparam int NDIG  = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt;
  logic [REM_W-1:0]       rem;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [3:0]             top_digit;

  assign value_u   = VALUE_WIDTH'(value);
  assign top_digit = bcd[BCD_W-1 -: 4];

  // each digit of five or more gets three added before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value_u[VALUE_WIDTH-1];
      // most negative value wraps to itself, which is its unsigned magnitude
      mag <= value_u[VALUE_WIDTH-1] ? (~value_u + VALUE_WIDTH'(1)) : value_u;
      bcd <= '0;
      cnt <= CNT_W'(VALUE_WIDTH);
      rem <= REM_W'(NDIG);
    end else if (cmd.conv_step) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end else if (cmd.shift_digit || cmd.load_digit) begin
      bcd <= {bcd[BCD_W-5:0], 4'd0};
      rem <= rem - REM_W'(1);
    end
    if (cmd.load_sign) begin
      char_code <= CH_MINUS;
      last      <= 1'b0;
    end else if (cmd.load_digit) begin
      char_code <= CH_ZERO + {4'd0, top_digit};
      last      <= (rem == REM_W'(1));
    end
  end

  assign sts.cnt_last = (cnt == CNT_W'(1));
  assign sts.top_zero = (top_digit == 4'd0);
  assign sts.rem_one  = (rem == REM_W'(1));
  assign sts.negative = neg;

endmodule

// ----- hdl/sidau_ctrl.sv -----
// sequencer for load, conversion, leading zero skip and character output
module sidau_ctrl import sidau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sidau_sts_t sts,
  output sidau_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CONV,
    SKIP,
    SIGN,
    DIGS
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load        = in_valid;
      CONV: cmd.conv_step   = 1'b1;
      SKIP: cmd.shift_digit = sts.top_zero && !sts.rem_one;
      SIGN: cmd.load_sign   = out_free;
      DIGS: cmd.load_digit  = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_sign || cmd.load_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) state <= CONV;
        end
        CONV: begin
          if (sts.cnt_last) state <= SKIP;
        end
        SKIP: begin
          if (!(sts.top_zero && !sts.rem_one)) begin
            state <= sts.negative ? SIGN : DIGS;
          end
        end
        SIGN: begin
          if (out_free) state <= DIGS;
        end
        DIGS: begin
          if (out_free && sts.rem_one) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/signed_int_to_decimal_ascii_unit.sv -----
// The shift-add-3 converter takes one magnitude bit a cycle; then one digit a cycle goes to the
// leading zero scan and, while the receiver does not stall the output, to the output. NDIG, the
// digit count, is ten at 32 bits. The next item is taken while the last character waits.
// Reset (rst, synchronous) returns the sequencer to idle and drops the output valid.
`include "signed_int_to_decimal_ascii_unit_macros.svh"
module signed_int_to_decimal_ascii_unit import sidau_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  sidau_in_if.sink   in_ch,
  sidau_out_if.source out_ch
);

  sidau_cmd_t cmd;
  sidau_sts_t sts;
  logic       in_take;
  logic       out_take;
  logic       char_ok;

  sidau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sidau_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (in_ch.value),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (out_ch.char_code),
    .last      (out_ch.last)
  );

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;
  assign char_ok  = (out_ch.char_code == CH_MINUS) ||
                    ((out_ch.char_code >= CH_ZERO) && (out_ch.char_code <= CH_ZERO + 8'd9));

  // no new item while the run before it is still incomplete
  `SIDAU_ASSERT_IMP(a_accept_only_after_run, clk, rst, in_take, !(out_ch.valid && !out_ch.last))
  // busy straight after an item is taken
  `SIDAU_ASSERT_NXT(a_busy_after_accept, clk, rst, in_take, !in_ch.ready)
  // characters of one run follow without gaps
  `SIDAU_ASSERT_NXT(a_run_no_gap, clk, rst, out_take && !out_ch.last, out_ch.valid)
  // only a minus sign or a decimal digit leaves
  `SIDAU_ASSERT_IMP(a_char_legal, clk, rst, out_ch.valid, char_ok)

endmodule

// ----- sim/tb_signed_int_to_decimal_ascii_unit.sv -----
// testbench for the signed integer to decimal text unit: directed, random and back-to-back items
module tb_signed_int_to_decimal_ascii_unit;
  import sidau_pkg::*;

  localparam int VW = 32;
  localparam int DEC_BASE = 10;
  localparam int CLK_HALF = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_item_t;

  logic clk;
  logic rst;

  sidau_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  sidau_out_if out_ch ();

  signed_int_to_decimal_ascii_unit #(.VALUE_WIDTH(VW)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  char_item_t  expected_chars[$];
  int          mismatches;
  int          cycles;
  bit          idle_on;
  int          stall_left;
  int unsigned pow10[0:9];

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // decimal text of one integer, sign first, digits most significant first
  function automatic void queue_decimal_text(logic signed [VW-1:0] v);
    logic [VW-1:0] mag;
    logic [7:0]    digits[$];
    char_item_t    c;
    mag = v;
    if (v[VW-1]) begin
      // also right for the most negative value, taken as an unsigned magnitude
      mag = ~mag + 1'b1;
      c.char_code = CH_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    if (mag == '0) begin
      digits.push_back(CH_ZERO);
    end
    while (mag != '0) begin
      digits.push_front(CH_ZERO + 8'(mag % DEC_BASE));
      mag = mag / DEC_BASE;
    end
    foreach (digits[i]) begin
      c.char_code = digits[i];
      c.last = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // one item on the input channel; valid stays high unless a gap follows
  task automatic send_value(input logic signed [VW-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      in_ch.value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    queue_decimal_text(v);
  endtask

  // receiver: check each character against the oldest expectation, with random stall bursts while idle_on
  always @(posedge clk) begin
    char_item_t exp_c;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                   $time, out_ch.char_code, out_ch.last);
        end else begin
          exp_c = expected_chars.pop_front();
          if (out_ch.char_code !== exp_c.char_code) begin
            mismatches++;
            $display("%0t: char_code mismatch: expected %0d, actual %0d",
                     $time, exp_c.char_code, out_ch.char_code);
          end
          if (out_ch.last !== exp_c.last) begin
            mismatches++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_c.last, out_ch.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic signed [VW-1:0] random_value();
    logic signed [VW-1:0] v;
    int unsigned          p;
    p = pow10[$urandom_range(0, 9)];
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: v = p + $urandom_range(0, 2) - 1;
      3: v = $urandom_range(0, p);
      default: v = {1'b1, VW'($urandom)} >> 1 | {1'b1, {(VW-1){1'b0}}};
    endcase
    if ($urandom_range(0, 1) == 1 && v != {1'b1, {(VW-1){1'b0}}}) v = -v;
    return v;
  endfunction

  task automatic test_extremes_and_specials();
    logic signed [VW-1:0] vals[$];
    vals = {0, 1, -1, 5, -5, 9, 10, -10, 99, 100, -100, 101, 1000000000, -1000000000,
            999999999, 123456789, -123456789, 1999999999, 2147483647, -2147483647,
            32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 7};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_values();
    repeat (50) send_value(random_value());
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (25) send_value(random_value());
  endtask

  task automatic drain_and_settle();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    mismatches = 0;
    cycles = 0;
    idle_on = 1'b1;
    pow10[0] = 1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * DEC_BASE;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_extremes_and_specials();
    test_random_values();
    test_back_to_back();
    in_ch.valid <= 1'b0;
    drain_and_settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sidau_pkg.sv
hdl/sidau_if.sv
hdl/sidau_datapath.sv
hdl/sidau_ctrl.sv
hdl/signed_int_to_decimal_ascii_unit.sv
sim/tb_signed_int_to_decimal_ascii_unit.sv
